FILE: rtl/vi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vi_pkg
// Shared types and codes for the vortex indicator core.
// ----------------------------------------------------------------------------
package vi_pkg;
	typedef enum logic [1:0] {
		KIND_PRIME  = 2'd0,
		KIND_UPDATE = 2'd1,
		KIND_ADD    = 2'd2,
		KIND_SPARE  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CALC  = 5'b00010,
		ST_PUSH  = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;
endpackage
`default_nettype wire

FILE: rtl/vi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vi_if
// Valid/ready channels carrying bars in and vortex ratios out.
// ----------------------------------------------------------------------------
interface vi_bar_if #(parameter int PRICE_BITS = 32);
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic signed [PRICE_BITS-1:0] close_price;
	logic signed [PRICE_BITS-1:0] high_price;
	logic signed [PRICE_BITS-1:0] low_price;
	modport source (output valid, kind, close_price, high_price, low_price, input ready);
	modport sink (input valid, kind, close_price, high_price, low_price, output ready);
endinterface

interface vi_res_if #(parameter int PRICE_BITS = 32);
	logic valid;
	logic ready;
	logic signed [PRICE_BITS-1:0] vi_plus;
	logic signed [PRICE_BITS-1:0] vi_minus;
	logic zero_range;
	modport source (output valid, vi_plus, vi_minus, zero_range, input ready);
	modport sink (input valid, vi_plus, vi_minus, zero_range, output ready);
endinterface
`default_nettype wire

FILE: rtl/vortex_indicator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vortex_indicator_core
// Vortex indicator VI+/VI- over fixed-point bars, running window sums and
// bit-serial restoring division.
// ----------------------------------------------------------------------------
// One bar is worked at a time. A prime word goes straight to the output
// state and reaches the result register once that is free. Any other word
// passes the calc and push states and then the shared one-bit-per-cycle
// divider, which computes VI+ and then VI-, each over a PRICE_BITS+FRAC_BITS+9
// bit dividend, after an operand load and ending with a final shift.
// A zero range total skips the division at the load step. The next bar is
// taken the cycle after the result is loaded. The result register lets a new
// bar enter while a result still waits; a finished bar holds in its last
// state until the register frees. Window stores are WINDOW-1 deep and hold
// committed values; only filled entries are used.
module vortex_indicator_core
	import vi_pkg::*;
#(
	parameter int WINDOW     = 21,
	parameter int PRICE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input wire clk,
	input wire arst_n,
	vi_bar_if.sink bar,
	vi_res_if.source res
);
	localparam int DEPTH = WINDOW - 1;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = PRICE_BITS + 9;     // sums of up to 512 entries
	localparam int EW = PRICE_BITS + 2;     // price differences
	localparam int NW = SW + FRAC_BITS;     // shifted dividend magnitude
	localparam int BW = $clog2(NW + 1);
	localparam logic signed [EW-1:0] PMAX_E = EW'({(PRICE_BITS-1){1'b1}});
	localparam logic signed [EW-1:0] PMIN_E = -PMAX_E - EW'(1);
	localparam logic [NW:0] LIM_P = (NW+1)'(PMAX_E);

	state_t state_q;
	logic signed [PRICE_BITS-1:0] prev_close_q, prev_high_q, prev_low_q;
	logic signed [PRICE_BITS-1:0] c_q, h_q, l_q;
	logic [1:0] kind_q;
	logic signed [PRICE_BITS-1:0] u_q, d_q, r_q;
	logic signed [SW-1:0] up_sum_q, down_sum_q, range_sum_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] slot_q;
	logic started_q;
	logic signed [PRICE_BITS-1:0] up_mem [DEPTH];
	logic signed [PRICE_BITS-1:0] dn_mem [DEPTH];
	logic signed [PRICE_BITS-1:0] rg_mem [DEPTH];
	logic signed [PRICE_BITS-1:0] old_u_q, old_d_q, old_r_q;
	logic second_q;
	logic [NW-1:0] num_q;
	logic [SW-1:0] den_q;
	logic [SW:0] rem_q;
	logic [NW:0] quo_q;
	logic [BW-1:0] bit_q;
	logic neg_q;
	logic signed [SW-1:0] dnum_q;
	logic signed [PRICE_BITS-1:0] vp_q, vm_q;
	logic zs_q;
	logic out_v_q, zr_q;
	logic signed [PRICE_BITS-1:0] o_vp_q, o_vm_q;

	function automatic logic signed [PRICE_BITS-1:0] sat(input logic signed [EW-1:0] v);
		if (v > PMAX_E) return PMAX_E[PRICE_BITS-1:0];
		if (v < PMIN_E) return PMIN_E[PRICE_BITS-1:0];
		return v[PRICE_BITS-1:0];
	endfunction

	logic signed [EW-1:0] e_h, e_l, e_ph, e_pl, e_pc, t_u, t_d, t_r1, t_r2, t_r3, t_r;
	always_comb begin
		e_h = EW'(h_q); e_l = EW'(l_q);
		e_ph = EW'(prev_high_q); e_pl = EW'(prev_low_q); e_pc = EW'(prev_close_q);
		t_u = e_h - e_pl; if (t_u < 0) t_u = -t_u;
		t_d = e_l - e_ph; if (t_d < 0) t_d = -t_d;
		t_r1 = e_pc - e_l; t_r2 = e_h - e_l; t_r3 = e_h - e_pc;
		t_r = t_r1;
		if (t_r2 > t_r) t_r = t_r2;
		if (t_r3 > t_r) t_r = t_r3;
	end

	logic full;
	assign full = (fill_q >= CW'(DEPTH));
	assign bar.ready = (state_q == ST_IDLE);
	logic bar_acc;
	assign bar_acc = bar.valid && bar.ready;
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_v_q || res.ready);

	// Divider operand setup (dividend magnitude preshifted by FRAC_BITS).
	logic signed [SW-1:0] nsum, dsum;
	logic [SW-1:0] nmag, dmag;
	always_comb begin
		nsum = second_q ? dnum_q : (up_sum_q + SW'(u_q));
		dsum = range_sum_q + SW'(r_q);
		nmag = nsum[SW-1] ? SW'(-nsum) : SW'(nsum);
		dmag = dsum[SW-1] ? SW'(-dsum) : SW'(dsum);
	end

	logic [SW+1:0] trial;
	logic [SW:0] rsh;
	always_comb begin
		rsh = {rem_q[SW-1:0], num_q[NW-1]};
		trial = {1'b0, rsh} - {2'b0, den_q};
	end

	logic [NW:0] lim;
	logic [NW:0] qs;
	logic signed [PRICE_BITS-1:0] qv;
	always_comb begin
		lim = neg_q ? LIM_P + (NW+1)'(1) : LIM_P;
		qs = (quo_q > lim) ? lim : quo_q;
		qv = neg_q ? PRICE_BITS'(-qs) : PRICE_BITS'(qs);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			old_u_q <= up_mem[slot_q];
			old_d_q <= dn_mem[slot_q];
			old_r_q <= rg_mem[slot_q];
		end
		if (state_q == ST_PUSH && (kind_q == KIND_ADD || !started_q)) begin
			up_mem[slot_q] <= u_q;
			dn_mem[slot_q] <= d_q;
			rg_mem[slot_q] <= r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			prev_close_q <= '0; prev_high_q <= '0; prev_low_q <= '0;
			up_sum_q <= '0; down_sum_q <= '0; range_sum_q <= '0;
			fill_q <= '0; slot_q <= '0; started_q <= 1'b0;
			out_v_q <= 1'b0; second_q <= 1'b0;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			case (state_q)
			ST_IDLE: begin
				if (bar_acc) begin
					kind_q <= bar.kind; c_q <= bar.close_price;
					h_q <= bar.high_price; l_q <= bar.low_price;
					if (bar.kind == KIND_PRIME) begin
						prev_close_q <= bar.close_price;
						prev_high_q <= bar.high_price;
						prev_low_q <= bar.low_price;
						vp_q <= '0; vm_q <= '0; zs_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_CALC;
					end
				end
			end
			ST_CALC: begin
				u_q <= sat(t_u); d_q <= sat(t_d); r_q <= sat(t_r);
				state_q <= ST_PUSH;
			end
			ST_PUSH: begin
				// Updates before the first commit seed; adds push after dividing,
				// but the divider takes the sums as they stand plus this bar either way.
				if (kind_q != KIND_ADD && !started_q) begin
					if (full) begin
						up_sum_q <= up_sum_q - SW'(old_u_q) + SW'(u_q);
						down_sum_q <= down_sum_q - SW'(old_d_q) + SW'(d_q);
						range_sum_q <= range_sum_q - SW'(old_r_q) + SW'(r_q);
					end else begin
						up_sum_q <= up_sum_q + SW'(u_q);
						down_sum_q <= down_sum_q + SW'(d_q);
						range_sum_q <= range_sum_q + SW'(r_q);
						fill_q <= fill_q + CW'(1);
					end
					slot_q <= (slot_q == AW'(DEPTH-1)) ? '0 : slot_q + AW'(1);
					started_q <= 1'b1;
				end
				state_q <= ST_DIV;
				second_q <= 1'b0;
				bit_q <= '0;
			end
			ST_DIV: begin
				if (bit_q == '0) begin
					// load operands
					if (!second_q) begin
						dnum_q <= down_sum_q + SW'(d_q);
					end
					num_q <= NW'(nmag) << FRAC_BITS;
					den_q <= dmag;
					neg_q <= (nsum[SW-1] != dsum[SW-1]) && (dsum != '0);
					rem_q <= '0; quo_q <= '0;
					bit_q <= BW'(1);
					if (dsum == '0) begin
						vp_q <= '0; vm_q <= '0; zs_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end else begin
					rem_q <= trial[SW+1] ? rsh : trial[SW:0];
					quo_q <= {quo_q[NW-1:0], ~trial[SW+1]};
					num_q <= num_q << 1;
					if (bit_q == BW'(NW)) bit_q <= BW'(NW + 1);
					else if (bit_q == BW'(NW + 1)) begin
						// quotient complete after final shift
						bit_q <= '0;
						if (!second_q) begin
							vp_q <= qv; second_q <= 1'b1;
						end else begin
							vm_q <= qv; zs_q <= 1'b0;
							state_q <= ST_OUT;
						end
					end else bit_q <= bit_q + BW'(1);
				end
			end
			ST_OUT: begin
				// hold until the result register is free, then commit an add bar and go idle
				if (out_load) begin
					if (kind_q == KIND_ADD) begin
						if (full) begin
							up_sum_q <= up_sum_q - SW'(old_u_q) + SW'(u_q);
							down_sum_q <= down_sum_q - SW'(old_d_q) + SW'(d_q);
							range_sum_q <= range_sum_q - SW'(old_r_q) + SW'(r_q);
						end else begin
							up_sum_q <= up_sum_q + SW'(u_q);
							down_sum_q <= down_sum_q + SW'(d_q);
							range_sum_q <= range_sum_q + SW'(r_q);
							fill_q <= fill_q + CW'(1);
						end
						slot_q <= (slot_q == AW'(DEPTH-1)) ? '0 : slot_q + AW'(1);
						started_q <= 1'b1;
						prev_close_q <= c_q; prev_high_q <= h_q; prev_low_q <= l_q;
					end
					o_vp_q <= vp_q; o_vm_q <= vm_q; zr_q <= zs_q;
					state_q <= ST_IDLE;
				end
			end
			default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid = out_v_q;
	assign res.vi_plus = o_vp_q;
	assign res.vi_minus = o_vm_q;
	assign res.zero_range = zr_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		bar.ready |-> (state_q == ST_IDLE)) else $error("ready outside idle");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH)) else $error("fill overflow");
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> started_q) else $error("fill without start");
	a_zr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.zero_range) |-> (res.vi_plus == '0 && res.vi_minus == '0))
		else $error("zero range with nonzero ratio");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable(res.vi_plus)
		&& $stable(res.vi_minus) && $stable(res.zero_range)))
		else $error("result word changed while waiting");
`endif
endmodule
`default_nettype wire
